/* rtl/udt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udt_pkg
// Shared widths, register indexes, band codes and the band classifier.
// ----------------------------------------------------------------------------
package udt_pkg;

   localparam int KEY_W   = 22;
   localparam int COUNT_W = 32;
   localparam int BAND_W  = 2;
   localparam int CSR_IDX_W = 8;

   localparam int DEFAULT_TABLE_DEPTH = 128;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FLOOR     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RENICE_FLOOR  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_FLOOR   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_CEILING = 8'd3;

   localparam logic [COUNT_W-1:0] RST_MIN_FLOOR     = 32'd30;
   localparam logic [COUNT_W-1:0] RST_RENICE_FLOOR  = 32'd41;
   localparam logic [COUNT_W-1:0] RST_PAUSE_FLOOR   = 32'd51;
   localparam logic [COUNT_W-1:0] RST_PAUSE_CEILING = 32'd60;

   localparam logic [BAND_W-1:0] BAND_NONE   = 2'd0;
   localparam logic [BAND_W-1:0] BAND_MIN    = 2'd1;
   localparam logic [BAND_W-1:0] BAND_RENICE = 2'd2;
   localparam logic [BAND_W-1:0] BAND_PAUSE  = 2'd3;

   typedef struct packed {
      logic [COUNT_W-1:0] min_floor;
      logic [COUNT_W-1:0] renice_floor;
      logic [COUNT_W-1:0] pause_floor;
      logic [COUNT_W-1:0] pause_ceiling;
   } band_cfg_type;

   // first band that contains the delta wins
   function automatic logic [BAND_W-1:0] band_of(input logic [COUNT_W-1:0] d,
                                                 input band_cfg_type cfg);
      logic [BAND_W-1:0] band;
      band = BAND_NONE;
      if (d >= cfg.min_floor && d < cfg.renice_floor) begin
         band = BAND_MIN;
      end else if (d >= cfg.renice_floor && d < cfg.pause_floor) begin
         band = BAND_RENICE;
      end else if (d >= cfg.pause_floor && d <= cfg.pause_ceiling) begin
         band = BAND_PAUSE;
      end
      return band;
   endfunction

endpackage
`default_nettype wire

/* rtl/udt_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udt_cfg
// Band threshold registers behind the csr write channel.
// ----------------------------------------------------------------------------
module udt_cfg
   import udt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]   csr_wdata,
   output band_cfg_type              cfg
);

   band_cfg_type cfg_ff;
   band_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_FLOOR:     cfg_in.min_floor     = csr_wdata;
            CSR_RENICE_FLOOR:  cfg_in.renice_floor  = csr_wdata;
            CSR_PAUSE_FLOOR:   cfg_in.pause_floor   = csr_wdata;
            CSR_PAUSE_CEILING: cfg_in.pause_ceiling = csr_wdata;
            default:           cfg_in = cfg_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_floor     <= RST_MIN_FLOOR;
         cfg_ff.renice_floor  <= RST_RENICE_FLOOR;
         cfg_ff.pause_floor   <= RST_PAUSE_FLOOR;
         cfg_ff.pause_ceiling <= RST_PAUSE_CEILING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/udt_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udt_store
// Key and last-count memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
module udt_store
   import udt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
   input  wire logic               clock,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [KEY_W-1:0]   rd_key,
   output logic      [COUNT_W-1:0] rd_count,
   input  wire logic               key_wr_en,
   input  wire logic               count_wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [KEY_W-1:0]   wr_key,
   input  wire logic [COUNT_W-1:0] wr_count
);

   logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
   logic [COUNT_W-1:0] count_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]   rd_key_ff;
   logic [COUNT_W-1:0] rd_count_ff;

   assign rd_key   = rd_key_ff;
   assign rd_count = rd_count_ff;

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (count_wr_en) begin
         count_mem[wr_addr] <= wr_count;
      end
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_count_ff <= count_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/usage_delta_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usage_delta_table
// Per-key tick delta tracker: linear search of a key table, delta against the
// stored count, append on a miss when there is room, and banding of the delta.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+---------------------
//   request | req_process_id, req_counter_value      | start & !busy
//   result  | rsp_usage_delta/band, new_entry, full  | rsp_strobe, 1 cycle
//   csr     | csr_index, csr_wdata                   | csr_valid & csr_ready
//
// The search reads one table entry per cycle through the single memory read
// port and compares it in the following cycle. A hit goes from SCAN to RESP; a
// miss goes through MISS, which appends the entry (or flags a full table), and
// then RESP, which bands the delta; an empty table goes straight to MISS.
// busy drops with the strobe, so the next word can be taken at the edge that
// ends the strobe cycle. Reset clears the state, fill count, pend flag and
// strobe, not the other registers or the table memory. Results cannot be stalled.
// ----------------------------------------------------------------------------
module usage_delta_table
   import udt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [KEY_W-1:0]     req_process_id,
   input  wire logic [COUNT_W-1:0]   req_counter_value,
   output logic                      rsp_strobe,
   output logic      [COUNT_W-1:0]   rsp_usage_delta,
   output logic      [BAND_W-1:0]    rsp_usage_band,
   output logic                      rsp_new_entry,
   output logic                      rsp_table_full,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]   csr_wdata
);

   localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   band_cfg_type cfg;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]  pend_idx_ff, pend_idx_in;
   logic               pend_ff, pend_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] delta_ff, delta_in;
   logic               new_ff, new_in;
   logic               full_ff, full_in;
   logic               strobe_ff, strobe_in;
   logic [BAND_W-1:0]  band_ff, band_in;

   logic               rd_en;
   logic [KEY_W-1:0]   rd_key;
   logic [COUNT_W-1:0] rd_count;
   logic               key_wr_en;
   logic               count_wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               match;

   udt_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   udt_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock       (clock),
      .rd_en       (rd_en),
      .rd_addr     (idx_ff[ADDR_W-1:0]),
      .rd_key      (rd_key),
      .rd_count    (rd_count),
      .key_wr_en   (key_wr_en),
      .count_wr_en (count_wr_en),
      .wr_addr     (wr_addr),
      .wr_key      (key_ff),
      .wr_count    (count_ff)
   );

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_usage_delta = delta_ff;
   assign rsp_usage_band  = band_ff;
   assign rsp_new_entry   = new_ff;
   assign rsp_table_full  = full_ff;

   // read data of the entry issued last cycle
   assign match = pend_ff && (rd_key == key_ff);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      pend_idx_in = pend_idx_ff;
      pend_in     = 1'b0;
      key_in      = key_ff;
      count_in    = count_ff;
      delta_in    = delta_ff;
      new_in      = new_ff;
      full_in     = full_ff;
      strobe_in   = 1'b0;
      band_in     = band_ff;
      rd_en       = 1'b0;
      key_wr_en   = 1'b0;
      count_wr_en = 1'b0;
      wr_addr     = pend_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = req_process_id;
               count_in = req_counter_value;
               idx_in   = '0;
               delta_in = '0;
               new_in   = 1'b0;
               full_in  = 1'b0;
               state_in = (fill_ff == '0) ? ST_MISS : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               delta_in    = count_ff - rd_count;
               count_wr_en = 1'b1;
               state_in    = ST_RESP;
            end else if (idx_ff == fill_ff) begin
               state_in = ST_MISS;
            end else begin
               // issue the next entry, compare it next cycle
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[ADDR_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
            end
         end
         ST_MISS: begin
            if (fill_ff != DEPTH_C) begin
               wr_addr     = fill_ff[ADDR_W-1:0];
               key_wr_en   = 1'b1;
               count_wr_en = 1'b1;
               fill_in     = fill_ff + CNT_W'(1);
               new_in      = 1'b1;
            end else begin
               full_in = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            band_in   = band_of(delta_ff, cfg);
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      key_ff      <= key_in;
      count_ff    <= count_in;
      delta_ff    <= delta_in;
      new_ff      <= new_in;
      full_ff     <= full_in;
      band_ff     <= band_in;
   end

endmodule
`default_nettype wire
